// ===== sv/bgvs_pkg.sv =====
// Shared types and constants for the block-growth vector stack.
// No dependencies; every other module of the block imports this package.
`timescale 1ns / 1ps

package bgvs_pkg;

    // Default sizing for the physical store and the items
    localparam int unsigned DEPTH_DEF      = 1024;
    localparam int unsigned ITEM_WIDTH_DEF = 32;

    // Width of counts, capacities, indexes and the two config registers
    localparam int unsigned CNT_W = 11;

    // Reset values of the config registers
    localparam logic [CNT_W-1:0] INIT_CAP_RST   = 11'd16;
    localparam logic [CNT_W-1:0] BLOCK_SIZE_RST = 11'd16;

    // Queue between front and back end
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned QP_W    = $clog2(Q_DEPTH);
    localparam int unsigned QF_W    = $clog2(Q_DEPTH + 1);

    // Config register indexes (paddr[2])
    localparam logic REG_INIT_CAP   = 1'b0;
    localparam logic REG_BLOCK_SIZE = 1'b1;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NULL_ITEM = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_NO_MEMORY = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_BAD_INDEX = 3'd5
    } status_t;

    // Classified command, as the front end hands it to the back end
    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] idx;
        logic             val_null;
        logic             idx_zero;
    } cmd_t;

    // Configuration as seen by the back end
    typedef struct packed {
        logic             init_load;
        logic [CNT_W-1:0] init_cap;
        logic [CNT_W-1:0] block_size;
    } cfg_t;

endpackage

// ===== sv/block_growth_vector_stack_top.sv =====
// Top level of the block-growth vector stack: config registers and wiring.
// Depends on bgvs_pkg, bgvs_front, bgvs_queue and bgvs_back.
`timescale 1ns / 1ps

// Stack of ITEM_WIDTH-bit items with push, pop and 1-based indexed read and
// write, plus a logical capacity that grows and shrinks in steps of block_size.
// A command is taken when start is high and busy is low. Its result shows on
// the result ports for exactly one cycle, marked by result_valid, once the
// command has passed through the queue and then the result register. The
// receiver cannot hold results off. The back end retires one command per
// cycle with a single access to the item memory. The two-entry command queue
// therefore never holds more than one command, busy stays low, and commands
// may follow back to back at one per clock. Results come out in command
// order. The store needs no clearing after reset: the stack is empty and the
// capacity equals initial_capacity (16). Configuration is written through
// the APB port at byte address 0 (initial_capacity) and 4 (block_size), by
// the user only while no command is in flight; the block does not enforce it.

module block_growth_vector_stack_top
    import bgvs_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEF,
    parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  start,
    input  logic [1:0]            op,
    input  logic [CNT_W-1:0]      index,
    input  logic [ITEM_WIDTH-1:0] value,
    output logic                  busy,
    output logic                  result_valid,
    output logic [2:0]            status,
    output logic [ITEM_WIDTH-1:0] read_value,
    output logic [CNT_W-1:0]      item_count,
    output logic [CNT_W-1:0]      capacity_now
);

    localparam int unsigned QD_W = $bits(cmd_t) + ITEM_WIDTH;

    logic [CNT_W-1:0]      init_cap_reg;
    logic [CNT_W-1:0]      init_cap_next;
    logic [CNT_W-1:0]      block_size_reg;
    logic [CNT_W-1:0]      block_size_next;
    logic                  cfg_wr;
    cfg_t                  cfg;

    logic                  q_push;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    cmd_t                  push_cmd;
    logic [ITEM_WIDTH-1:0] push_value;
    logic [QD_W-1:0]       q_dout;
    cmd_t                  q_cmd;
    logic [ITEM_WIDTH-1:0] q_value;

    // Config write transfer
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        init_cap_next   = init_cap_reg;
        block_size_next = block_size_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_INIT_CAP:   init_cap_next   = pwdata[CNT_W-1:0];
                REG_BLOCK_SIZE: block_size_next = pwdata[CNT_W-1:0];
                default:        init_cap_next   = init_cap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cap_reg   <= INIT_CAP_RST;
            block_size_reg <= BLOCK_SIZE_RST;
        end
        else
        begin
            init_cap_reg   <= init_cap_next;
            block_size_reg <= block_size_next;
        end
    end

    // Config read-back
    always_comb
    begin
        case (paddr[2])
            REG_INIT_CAP:   prdata = {{(32 - CNT_W){1'b0}}, init_cap_reg};
            REG_BLOCK_SIZE: prdata = {{(32 - CNT_W){1'b0}}, block_size_reg};
            default:        prdata = '0;
        endcase
    end

    // Hand current config and the capacity reload strobe to the back end
    always_comb
    begin
        cfg.init_load  = cfg_wr && (paddr[2] == REG_INIT_CAP);
        cfg.init_cap   = init_cap_next;
        cfg.block_size = block_size_reg;
    end

    bgvs_front #(
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_front (
        .start      (start),
        .op         (op),
        .index      (index),
        .value      (value),
        .queue_full (q_full),
        .busy       (busy),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_value (push_value)
    );

    bgvs_queue #(
        .DATA_W (QD_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({push_cmd, push_value}),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .full  (q_full)
    );

    assign q_cmd   = cmd_t'(q_dout[QD_W-1:ITEM_WIDTH]);
    assign q_value = q_dout[ITEM_WIDTH-1:0];

    bgvs_back #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (!q_empty),
        .cmd          (q_cmd),
        .cmd_value    (q_value),
        .cfg          (cfg),
        .cmd_take     (q_pop),
        .result_valid (result_valid),
        .status       (status),
        .read_value   (read_value),
        .item_count   (item_count),
        .capacity_now (capacity_now)
    );

endmodule

// ===== sv/bgvs_queue.sv =====
// Short flop-based FIFO decoupling the front end from the back end.
// Depends on bgvs_pkg for the queue depth and pointer widths.
`timescale 1ns / 1ps

module bgvs_queue
    import bgvs_pkg::*;
#(
    parameter int unsigned DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] din,
    input  logic              pop,
    output logic [DATA_W-1:0] dout,
    output logic              empty,
    output logic              full
);

    logic [DATA_W-1:0] data_reg [Q_DEPTH];
    logic [QP_W-1:0]   wptr_reg;
    logic [QP_W-1:0]   wptr_next;
    logic [QP_W-1:0]   rptr_reg;
    logic [QP_W-1:0]   rptr_next;
    logic [QF_W-1:0]   fill_reg;
    logic [QF_W-1:0]   fill_next;
    logic              do_push;
    logic              do_pop;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == QF_W'(Q_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = data_reg[rptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == QP_W'(Q_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == QP_W'(Q_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    // Store payload on push
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wptr_reg] <= din;
        end
    end

endmodule

// ===== sv/bgvs_front.sv =====
// Front end: takes commands off the start/busy port and classifies them.
// Depends on bgvs_pkg for the command type; feeds bgvs_queue.
`timescale 1ns / 1ps

module bgvs_front
    import bgvs_pkg::*;
#(
    parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF
)
(
    input  logic                  start,
    input  logic [1:0]            op,
    input  logic [CNT_W-1:0]      index,
    input  logic [ITEM_WIDTH-1:0] value,
    input  logic                  queue_full,
    output logic                  busy,
    output logic                  push,
    output cmd_t                  push_cmd,
    output logic [ITEM_WIDTH-1:0] push_value
);

    // Hold off new commands only while the queue is full
    assign busy = queue_full;
    assign push = start && !queue_full;

    // Classify: decode op, flag a null item and a zero index
    always_comb
    begin
        push_cmd.op       = op_t'(op);
        push_cmd.idx      = index;
        push_cmd.val_null = (value == '0);
        push_cmd.idx_zero = (index == '0);
    end

    assign push_value = value;

endmodule

// ===== sv/bgvs_back.sv =====
// Back end: executes stack commands against the item store and the counters.
// Depends on bgvs_pkg; holds the item memory and the result register.
`timescale 1ns / 1ps

module bgvs_back
    import bgvs_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEF,
    parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    input  logic [ITEM_WIDTH-1:0] cmd_value,
    input  cfg_t                  cfg,
    output logic                  cmd_take,
    output logic                  result_valid,
    output logic [2:0]            status,
    output logic [ITEM_WIDTH-1:0] read_value,
    output logic [CNT_W-1:0]      item_count,
    output logic [CNT_W-1:0]      capacity_now
);

    localparam int unsigned AW      = $clog2(DEPTH);
    localparam logic [31:0] DEPTH_W = 32'(DEPTH);

    logic [ITEM_WIDTH-1:0] mem [DEPTH];
    logic [ITEM_WIDTH-1:0] rdata_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_next;

    logic             res_valid_reg;
    logic             res_valid_next;
    status_t          res_status_reg;
    status_t          res_status_next;
    logic             res_rd_reg;
    logic             res_rd_next;

    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_addr;

    logic [CNT_W:0]   grown;
    logic [CNT_W:0]   twice;
    logic [CNT_W:0]   cap_ext;
    logic             full;
    logic             shrink;

    assign cmd_take = cmd_valid;

    assign cap_ext = {1'b0, cap_reg};
    assign grown   = cap_ext + {1'b0, cfg.block_size};
    assign twice   = {cfg.block_size, 1'b0};
    assign full    = (count_reg >= cap_reg);
    assign shrink  = (cap_reg > cfg.init_cap) &&
                     ((cap_ext < twice) || ({1'b0, count_reg} <= cap_ext - twice));

    // Decide status, counter updates and the memory access for one command
    always_comb
    begin
        count_next      = count_reg;
        cap_next        = cap_reg;
        res_valid_next  = 1'b0;
        res_status_next = ST_OK;
        res_rd_next     = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = AW'(count_reg);

        if (cmd_valid)
        begin
            res_valid_next = 1'b1;
            case (cmd.op)
                OP_PUSH:
                begin
                    if (cmd.val_null)
                    begin
                        res_status_next = ST_NULL_ITEM;
                    end
                    else if (full && (cfg.block_size == '0))
                    begin
                        res_status_next = ST_OVERFLOW;
                    end
                    else if (full && ((32'(grown) > DEPTH_W) || grown[CNT_W]))
                    begin
                        res_status_next = ST_NO_MEMORY;
                    end
                    else
                    begin
                        if (full)
                        begin
                            cap_next = grown[CNT_W-1:0];
                        end
                        if (32'(count_reg) >= DEPTH_W)
                        begin
                            res_status_next = ST_NO_MEMORY;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_addr   = AW'(count_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                OP_POP:
                begin
                    if (count_reg == '0)
                    begin
                        res_status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        if (shrink)
                        begin
                            cap_next = (cap_reg >= cfg.block_size) ?
                                       cap_reg - cfg.block_size : '0;
                        end
                        mem_re      = 1'b1;
                        res_rd_next = 1'b1;
                        mem_addr    = AW'(count_reg - 1'b1);
                        count_next  = count_reg - 1'b1;
                    end
                end
                OP_READ,
                OP_WRITE:
                begin
                    if (cmd.idx_zero || (cmd.idx > count_reg))
                    begin
                        res_status_next = ST_BAD_INDEX;
                    end
                    else
                    begin
                        mem_addr = AW'(cmd.idx - 1'b1);
                        if (cmd.op == OP_READ)
                        begin
                            mem_re      = 1'b1;
                            res_rd_next = 1'b1;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res_status_next = ST_OK;
                end
            endcase
        end
        else if (cfg.init_load && (count_reg == '0))
        begin
            // Reload the capacity while the stack is empty and no command is taken
            cap_next = cfg.init_cap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            cap_reg        <= INIT_CAP_RST;
            res_valid_reg  <= 1'b0;
            res_status_reg <= ST_OK;
            res_rd_reg     <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            cap_reg        <= cap_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_rd_reg     <= res_rd_next;
        end
    end

    // Item store: one access per command, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= cmd_value;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Drive the result transfer; counters already hold the post-step values
    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign read_value   = res_rd_reg ? rdata_reg : '0;
    assign item_count   = count_reg;
    assign capacity_now = cap_reg;

endmodule

// ===== sv/bgvs_checker.sv =====
// Port-level checks for the block-growth vector stack, bound to the top level.
// Depends on bgvs_pkg for status codes.
`timescale 1ns / 1ps

module bgvs_checker
    import bgvs_pkg::*;
#(
    parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  result_valid,
    input logic [2:0]            status,
    input logic [ITEM_WIDTH-1:0] read_value,
    input logic [CNT_W-1:0]      item_count
);

    // Every accepted command yields a result once it has passed the queue and the result register
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 result_valid)
        else $error("accepted command produced no result");

    // No result without a matching accepted command
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 2))
        else $error("result without accepted command");

    // Failed commands return no data
    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != ST_OK)) |-> (read_value == '0))
        else $error("error result carries data");

    // Underflow only on an empty stack
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == ST_UNDERFLOW)) |-> (item_count == '0))
        else $error("underflow with items held");

endmodule

bind block_growth_vector_stack_top bgvs_checker #(
    .ITEM_WIDTH (ITEM_WIDTH)
) u_bgvs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .read_value   (read_value),
    .item_count   (item_count)
);

// ===== dv/testbench.sv =====
// Testbench for block_growth_vector_stack_top: directed and random commands
// checked against a built-in stack/capacity predictor. Depends on bgvs_pkg.
`timescale 1ns / 1ps

module testbench
    import bgvs_pkg::*;
();

    localparam int unsigned STORE_DEPTH = DEPTH_DEF;
    localparam int unsigned IDLE_LIMIT  = 1000;
    localparam int unsigned MAX_CNT     = 2047;

    // Expected outcome of one command
    typedef struct packed {
        status_t          st;
        logic [31:0]      rd;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] cap;
    } stack_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  start;
    logic [1:0]            op;
    logic [CNT_W-1:0]      index;
    logic [31:0]           value;
    logic                  busy;
    logic                  result_valid;
    logic [2:0]            status;
    logic [31:0]           read_value;
    logic [CNT_W-1:0]      item_count;
    logic [CNT_W-1:0]      capacity_now;

    // Predictor state: stack contents, fill level, capacity and registers
    logic [31:0]   stack_mem [STORE_DEPTH];
    int unsigned   held_count   = 0;
    int unsigned   cap_level    = INIT_CAP_RST;
    int unsigned   init_cap_cfg = INIT_CAP_RST;
    int unsigned   block_cfg    = BLOCK_SIZE_RST;

    stack_result_t pending_results [$];
    int unsigned   gap_pct;
    int unsigned   error_count     = 0;
    int unsigned   commands_sent   = 0;
    int unsigned   results_checked = 0;
    int unsigned   reg_writes      = 0;
    int unsigned   idle_cycles     = 0;
    int unsigned   status_hits [6] = '{default: 0};

    block_growth_vector_stack_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .op           (op),
        .index        (index),
        .value        (value),
        .busy         (busy),
        .result_valid (result_valid),
        .status       (status),
        .read_value   (read_value),
        .item_count   (item_count),
        .capacity_now (capacity_now)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Advance the stack model by one command and return its outcome
    function automatic stack_result_t predict_step(op_t o, logic [CNT_W-1:0] idx,
                                                   logic [31:0] v);
        stack_result_t r;
        int unsigned   grown;
        int unsigned   twice;
        bit            ok;
        r.st = ST_OK;
        r.rd = '0;
        case (o)
            OP_PUSH:
            begin
                if (v == 0)
                begin
                    r.st = ST_NULL_ITEM;
                end
                else
                begin
                    ok = 1'b1;
                    if (held_count >= cap_level)
                    begin
                        grown = cap_level + block_cfg;
                        if (block_cfg == 0)
                        begin
                            r.st = ST_OVERFLOW;
                            ok = 1'b0;
                        end
                        else if (grown > STORE_DEPTH || grown > MAX_CNT)
                        begin
                            r.st = ST_NO_MEMORY;
                            ok = 1'b0;
                        end
                        else
                        begin
                            cap_level = grown;
                        end
                    end
                    if (ok && held_count >= STORE_DEPTH)
                    begin
                        r.st = ST_NO_MEMORY;
                        ok = 1'b0;
                    end
                    if (ok)
                    begin
                        stack_mem[held_count] = v;
                        held_count++;
                    end
                end
            end
            OP_POP:
            begin
                if (held_count == 0)
                begin
                    r.st = ST_UNDERFLOW;
                end
                else
                begin
                    // Shrink test runs on the count before the pop
                    twice = 2 * block_cfg;
                    if (cap_level > init_cap_cfg &&
                        (cap_level < twice || held_count <= cap_level - twice))
                        cap_level = (cap_level >= block_cfg) ? cap_level - block_cfg : 0;
                    r.rd = stack_mem[held_count - 1];
                    held_count--;
                end
            end
            default:
            begin
                if (idx == 0 || idx > held_count)
                    r.st = ST_BAD_INDEX;
                else if (o == OP_READ)
                    r.rd = stack_mem[idx - 1];
                else
                    stack_mem[idx - 1] = v;
            end
        endcase
        r.cnt = held_count[CNT_W-1:0];
        r.cap = cap_level[CNT_W-1:0];
        return r;
    endfunction

    // Mostly in-range positions, with zero, one past the top and raw 11-bit noise
    function automatic logic [CNT_W-1:0] pick_index();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return '0;
        else if (sel < 14)
            return CNT_W'(held_count + 1);
        else if (sel < 26)
            return CNT_W'($urandom_range(0, MAX_CNT));
        else if (held_count == 0)
            return CNT_W'($urandom_range(1, 4));
        else
            return CNT_W'($urandom_range(1, held_count));
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return '0;
        else if (sel < 10)
            return '1;
        else if (sel < 14)
            return 32'd1 << $urandom_range(0, 31);
        else
            return $urandom;
    endfunction

    // Present one command, hold it until transferred, and queue its outcome
    task automatic send_cmd(op_t o, logic [CNT_W-1:0] idx, logic [31:0] v);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        op    = o;
        index = idx;
        value = v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_step(o, idx, v));
        commands_sent++;
        @(negedge clk);
    endtask

    // Drop start and wait for every outstanding result plus a short margin
    task automatic wait_idle();
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic reg_sel, logic [CNT_W-1:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = {21'd0, v};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_sel == REG_INIT_CAP)
        begin
            init_cap_cfg = v;
            if (held_count == 0)
                cap_level = v;
        end
        else
        begin
            block_cfg = v;
        end
        reg_writes++;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic read_reg(logic reg_sel);
        logic [31:0] want;
        want = (reg_sel == REG_INIT_CAP) ? init_cap_cfg : block_cfg;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {reg_sel, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
                     $time, reg_sel, want, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Register reset values, write and readback of both registers
    task automatic test_registers();
        read_reg(REG_INIT_CAP);
        read_reg(REG_BLOCK_SIZE);
        write_reg(REG_INIT_CAP, 11'd1024);
        write_reg(REG_BLOCK_SIZE, 11'd1024);
        read_reg(REG_INIT_CAP);
        read_reg(REG_BLOCK_SIZE);
        write_reg(REG_INIT_CAP, INIT_CAP_RST);
        write_reg(REG_BLOCK_SIZE, BLOCK_SIZE_RST);
        read_reg(REG_INIT_CAP);
        read_reg(REG_BLOCK_SIZE);
    endtask

    // Every operation, field extremes and the named corner cases
    task automatic test_directed();
        send_cmd(OP_POP, 11'd0, 32'd0);                 // underflow on empty
        send_cmd(OP_READ, 11'd1, 32'd0);                // index beyond count
        send_cmd(OP_WRITE, 11'd0, 32'h1234_5678);       // index zero
        send_cmd(OP_PUSH, 11'd0, 32'd0);                // null push
        send_cmd(OP_PUSH, 11'd0, 32'hFFFF_FFFF);
        send_cmd(OP_PUSH, 11'd2047, 32'd1);
        send_cmd(OP_PUSH, 11'd0, 32'h8000_0000);
        send_cmd(OP_READ, 11'd0, 32'hFFFF_FFFF);
        send_cmd(OP_READ, 11'd3, 32'd0);
        send_cmd(OP_READ, 11'd4, 32'd0);
        send_cmd(OP_READ, 11'd2047, 32'd0);
        send_cmd(OP_WRITE, 11'd2, 32'd0);               // store null in place
        send_cmd(OP_READ, 11'd2, 32'd0);
        send_cmd(OP_WRITE, 11'd3, 32'h5A5A_A5A5);
        send_cmd(OP_POP, 11'd2047, 32'hFFFF_FFFF);
        send_cmd(OP_POP, 11'd0, 32'd0);
        send_cmd(OP_POP, 11'd0, 32'd0);
        wait_idle();
        // No growth allowed: full at zero capacity
        write_reg(REG_INIT_CAP, 11'd0);
        write_reg(REG_BLOCK_SIZE, 11'd0);
        send_cmd(OP_PUSH, 11'd0, 32'd7);
        wait_idle();
        // One huge block: grow to the full store, then shrink on the wrapped test
        write_reg(REG_BLOCK_SIZE, 11'd1024);
        send_cmd(OP_PUSH, 11'd0, 32'd7);
        send_cmd(OP_POP, 11'd0, 32'd0);
        wait_idle();
        write_reg(REG_INIT_CAP, INIT_CAP_RST);
        write_reg(REG_BLOCK_SIZE, BLOCK_SIZE_RST);
    endtask

    // Random operation mix over a series of register settings
    task automatic test_random_mix(int unsigned segments, int unsigned per_segment);
        int unsigned sel;
        for (int s = 0; s < segments; s++)
        begin
            wait_idle();
            sel = $urandom_range(0, 3);
            write_reg(REG_INIT_CAP, (sel == 0) ? 11'd0 : (sel == 1) ? 11'd1024 :
                                    (sel == 2) ? INIT_CAP_RST :
                                    CNT_W'($urandom_range(0, 48)));
            sel = $urandom_range(0, 5);
            write_reg(REG_BLOCK_SIZE, (sel == 0) ? 11'd0 : (sel == 1) ? 11'd1 :
                                      (sel == 2) ? 11'd1024 :
                                      CNT_W'($urandom_range(1, 12)));
            for (int i = 0; i < per_segment; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 45)
                    send_cmd(OP_PUSH, CNT_W'($urandom_range(0, MAX_CNT)), pick_value());
                else if (sel < 70)
                    send_cmd(OP_POP, CNT_W'($urandom_range(0, MAX_CNT)), $urandom);
                else if (sel < 85)
                    send_cmd(OP_READ, pick_index(), $urandom);
                else
                    send_cmd(OP_WRITE, pick_index(), pick_value());
            end
        end
    endtask

    // Fill the whole store, hit out of memory and overflow, then drain half of it
    // while the capacity shrinks
    task automatic test_store_limit();
        while (held_count > 0)
            send_cmd(OP_POP, 11'd0, 32'd0);
        wait_idle();
        write_reg(REG_INIT_CAP, 11'd1024);
        write_reg(REG_BLOCK_SIZE, 11'd16);
        while (held_count < STORE_DEPTH)
        begin
            if ($urandom_range(0, 99) < 10)
                send_cmd(($urandom_range(0, 1) != 0) ? OP_READ : OP_WRITE,
                         pick_index(), pick_value());
            else
                send_cmd(OP_PUSH, 11'd0, pick_value());
        end
        send_cmd(OP_PUSH, 11'd0, 32'hDEAD_0001);        // out of memory
        send_cmd(OP_READ, 11'd1024, 32'd0);
        send_cmd(OP_WRITE, 11'd1025, 32'd3);
        wait_idle();
        write_reg(REG_BLOCK_SIZE, 11'd0);
        send_cmd(OP_PUSH, 11'd0, 32'hDEAD_0002);        // overflow
        send_cmd(OP_PUSH, 11'd0, 32'd0);
        wait_idle();
        // Lower floor without reload, so the drain shrinks capacity block by block
        write_reg(REG_INIT_CAP, 11'd64);
        write_reg(REG_BLOCK_SIZE, 11'd32);
        while (held_count > STORE_DEPTH / 2)
        begin
            if ($urandom_range(0, 99) < 8)
                send_cmd(OP_READ, pick_index(), 32'd0);
            else
                send_cmd(OP_POP, 11'd0, 32'd0);
        end
        send_cmd(OP_POP, 11'd0, 32'd0);
        wait_idle();
        write_reg(REG_INIT_CAP, INIT_CAP_RST);
        write_reg(REG_BLOCK_SIZE, BLOCK_SIZE_RST);
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : check_results
        stack_result_t exp_r;
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no command outstanding, status %0d",
                         $time, status);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                status_hits[int'(exp_r.st)]++;
                results_checked++;
                if (status !== exp_r.st)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp_r.st, status);
                    error_count++;
                end
                if (read_value !== exp_r.rd)
                begin
                    $display("%0t: read_value mismatch, expected %h, actual %h",
                             $time, exp_r.rd, read_value);
                    error_count++;
                end
                if (item_count !== exp_r.cnt)
                begin
                    $display("%0t: item_count mismatch, expected %0d, actual %0d",
                             $time, exp_r.cnt, item_count);
                    error_count++;
                end
                if (capacity_now !== exp_r.cap)
                begin
                    $display("%0t: capacity_now mismatch, expected %0d, actual %0d",
                             $time, exp_r.cap, capacity_now);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles with no transfer at all
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || result_valid === 1'b1 || (psel && penable))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        start   = 1'b0;
        op      = OP_PUSH;
        index   = '0;
        value   = '0;
        gap_pct = 31;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_registers();
        test_directed();
        test_random_mix(3, 60);
        gap_pct = 61;
        test_store_limit();
        gap_pct = 0;
        test_random_mix(3, 60);

        wait_idle();
        repeat (8) @(negedge clk);
        $display("Ran %0d commands and %0d register writes; %0d results checked.",
                 commands_sent, reg_writes, results_checked);
        $display("Outcomes ok/null/ovf/oom/underflow/index: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_hits[0], status_hits[1], status_hits[2],
                 status_hits[3], status_hits[4], status_hits[5]);
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bgvs_pkg.sv
sv/bgvs_queue.sv
sv/bgvs_front.sv
sv/bgvs_back.sv
sv/block_growth_vector_stack_top.sv
sv/bgvs_checker.sv
dv/testbench.sv
